// ===== sv/lfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants for the frame-over-SPI slave framer.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int unsigned STORE_DEPTH  = 64;
  localparam int unsigned STORE_AW     = $clog2(STORE_DEPTH);
  localparam int unsigned MAX_DATA_DEF = 64;
  localparam int unsigned TIMEOUT_W    = 20;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd50000;

  // item operations
  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_EMPTY = 2'd1,
    OP_TICK  = 2'd2,
    OP_LOAD  = 2'd3
  } op_t;

  // header direction codes
  localparam logic [1:0] DIR_RX = 2'd0;
  localparam logic [1:0] DIR_TX = 2'd1;

  // reported events
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ID      = 3'd1,
    EV_DATA    = 3'd2,
    EV_GOOD    = 3'd3,
    EV_BAD     = 3'd4,
    EV_TIMEOUT = 3'd5
  } ev_t;

  // frame phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ID      = 4'd1,
    PH_LEN     = 4'd2,
    PH_RX_DATA = 4'd3,
    PH_RX_CHK  = 4'd4,
    PH_TX_DATA = 4'd5,
    PH_TX_CHK  = 4'd6,
    PH_TX_DONE = 4'd7,
    PH_IGNORE  = 4'd8
  } phase_t;

  // sequencer states
  typedef enum logic [2:0] {
    SQ_READY = 3'd0,
    SQ_EXEC  = 3'd1,
    SQ_WALK  = 3'd2,
    SQ_FETCH = 3'd3,
    SQ_LOAD  = 3'd4,
    SQ_OUT   = 3'd5
  } seq_t;

  // reply codes
  localparam logic [7:0] RP_START   = 8'hF1;
  localparam logic [7:0] RP_ID      = 8'hF2;
  localparam logic [7:0] RP_RX_OK   = 8'hF3;
  localparam logic [7:0] RP_NO_DIR  = 8'hF4;
  localparam logic [7:0] RP_REJECT  = 8'hF5;
  localparam logic [7:0] RP_RX_DATA = 8'hF6;
  localparam logic [7:0] RP_RX_CHK  = 8'hF7;
  localparam logic [7:0] RP_TX_CHK  = 8'hF8;
  localparam logic [7:0] RP_TX_DONE = 8'hF9;
  localparam logic [7:0] RP_IGNORE  = 8'hFA;
  localparam logic [7:0] RP_EMPTY   = 8'hFB;
  localparam logic [7:0] RP_UNUSED  = 8'hFE;

endpackage

// ===== sv/lfs_stage_ram.sv =====
// ----------------------------------------------------------------------------
// lfs_stage_ram
// Transmit staging store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lfs_stage_ram import lfs_pkg::*; (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [STORE_AW-1:0] wr_addr,
  input  logic [7:0]          wr_data,
  input  logic [STORE_AW-1:0] rd_addr,
  output logic [7:0]          rd_data
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/lin_frame_over_spi_slave_unit.sv =====
// ----------------------------------------------------------------------------
// lin_frame_over_spi_slave_unit
// SPI-slave framer: id, length, data and checksum with per-byte replies.
// ----------------------------------------------------------------------------
// usage
// - item channel (item_valid / item_stall) carries one operation: a byte
//   exchange, a transmit-empty, a timer tick or a staging store load
// - every item gives exactly one result on the result channel
//   (result_valid / result_stall); frame_id and frame_len show the frame
//   state after that item
// - most items are worked in the exec state, which registers the result
//   that the out state then shows; a transmit header first runs the
//   checksum over the staging store through one 8-bit adder, one store read
//   a cycle, then reads the first data byte (none at a length of 0); a
//   transmit data byte other than the last does one store read
// - one item at a time: item_stall stays high from transfer in until the
//   result has been taken, so a stalled result holds the block
// - user writes timeout_ticks via cfg_we / cfg_wdata while idle, unenforced
// - rst (synchronous) returns the framer to idle with timeout 50000;
//   the staging store is not cleared and must be loaded before use
// ----------------------------------------------------------------------------
module lin_frame_over_spi_slave_unit import lfs_pkg::*; #(
  parameter int unsigned MAX_DATA = MAX_DATA_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [TIMEOUT_W-1:0] cfg_wdata,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [1:0]           operation,
  input  logic [7:0]           rx_byte,
  input  logic                 hdr_accept,
  input  logic [7:0]           hdr_len,
  input  logic [1:0]           hdr_dir,
  input  logic [5:0]           load_index,
  input  logic [7:0]           load_byte,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 reply_valid,
  output logic [7:0]           reply_byte,
  output logic [2:0]           event_res,
  output logic [15:0]          frame_id,
  output logic [7:0]           frame_len,
  output logic [5:0]           data_index,
  output logic [7:0]           data_byte
);

  seq_t                 seq, seq_next;
  phase_t               phase, phase_next;
  logic [15:0]          cur_id, cur_id_next;
  logic [7:0]           cur_len, cur_len_next;
  logic [7:0]           byte_pos, byte_pos_next;
  logic [7:0]           rx_sum, rx_sum_next;
  logic [7:0]           tx_check, tx_check_next;
  logic                 timer_running, timer_running_next;
  logic [TIMEOUT_W-1:0] tick_count, tick_count_next;
  logic [TIMEOUT_W-1:0] timeout_ticks;

  logic [7:0]           walk_cnt, walk_cnt_next;
  logic                 walk_pend, walk_pend_next;
  logic [7:0]           acc, acc_next;

  // latched item
  op_t                  it_op;
  logic [7:0]           it_rx;
  logic                 it_acc;
  logic [7:0]           it_len;
  logic [1:0]           it_dir;
  logic [5:0]           it_lidx;
  logic [7:0]           it_lbyte;

  logic                 res_valid, res_valid_next;
  logic [7:0]           res_reply, res_reply_next;
  ev_t                  res_event, res_event_next;
  logic [5:0]           res_didx, res_didx_next;
  logic [7:0]           res_dbyte, res_dbyte_next;

  logic                 ram_we;
  logic [STORE_AW-1:0]  ram_rd_addr;
  logic [7:0]           ram_rd_data;

  logic [7:0]           hdr_sum;
  logic [7:0]           pos_inc;
  logic [TIMEOUT_W-1:0] tick_inc;
  logic                 hdr_ok;

  lfs_stage_ram u_stage (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (it_lidx),
    .wr_data (it_lbyte),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign ram_we      = (seq == SQ_EXEC) && (it_op == OP_LOAD);
  assign ram_rd_addr = (seq == SQ_WALK) ? walk_cnt[STORE_AW-1:0] : byte_pos[STORE_AW-1:0];

  assign item_stall   = (seq != SQ_READY);
  assign result_valid = (seq == SQ_OUT);
  assign reply_valid  = res_valid;
  assign reply_byte   = res_reply;
  assign event_res    = res_event;
  assign frame_id     = cur_id;
  assign frame_len    = cur_len;
  assign data_index   = res_didx;
  assign data_byte    = res_dbyte;

  assign hdr_sum  = cur_id[15:8] + cur_id[7:0] + it_rx;
  assign pos_inc  = byte_pos + 8'd1;
  assign tick_inc = (tick_count != '1) ? tick_count + 1'b1 : tick_count;
  assign hdr_ok   = it_acc && (it_len == it_rx) && (it_rx <= 8'(MAX_DATA));

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      it_op    <= op_t'(operation);
      it_rx    <= rx_byte;
      it_acc   <= hdr_accept;
      it_len   <= hdr_len;
      it_dir   <= hdr_dir;
      it_lidx  <= load_index;
      it_lbyte <= load_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq           <= SQ_READY;
      phase         <= PH_IDLE;
      cur_id        <= '0;
      cur_len       <= '0;
      byte_pos      <= '0;
      rx_sum        <= '0;
      tx_check      <= '0;
      timer_running <= 1'b0;
      tick_count    <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else begin
      seq           <= seq_next;
      phase         <= phase_next;
      cur_id        <= cur_id_next;
      cur_len       <= cur_len_next;
      byte_pos      <= byte_pos_next;
      rx_sum        <= rx_sum_next;
      tx_check      <= tx_check_next;
      timer_running <= timer_running_next;
      tick_count    <= tick_count_next;
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_cnt  <= walk_cnt_next;
    walk_pend <= walk_pend_next;
    acc       <= acc_next;
    res_valid <= res_valid_next;
    res_reply <= res_reply_next;
    res_event <= res_event_next;
    res_didx  <= res_didx_next;
    res_dbyte <= res_dbyte_next;
  end

  always_comb begin
    seq_next           = seq;
    phase_next         = phase;
    cur_id_next        = cur_id;
    cur_len_next       = cur_len;
    byte_pos_next      = byte_pos;
    rx_sum_next        = rx_sum;
    tx_check_next      = tx_check;
    timer_running_next = timer_running;
    tick_count_next    = tick_count;
    walk_cnt_next      = walk_cnt;
    walk_pend_next     = walk_pend;
    acc_next           = acc;
    res_valid_next     = res_valid;
    res_reply_next     = res_reply;
    res_event_next     = res_event;
    res_didx_next      = res_didx;
    res_dbyte_next     = res_dbyte;

    unique case (seq)
      SQ_READY: begin
        if (item_valid) begin
          seq_next = SQ_EXEC;
        end
      end

      SQ_EXEC: begin
        seq_next       = SQ_OUT;
        res_valid_next = 1'b0;
        res_reply_next = '0;
        res_event_next = EV_NONE;
        res_didx_next  = '0;
        res_dbyte_next = '0;
        unique case (it_op)
          OP_BYTE: begin
            res_valid_next = 1'b1;
            unique case (phase)
              PH_IDLE: begin
                res_reply_next     = RP_START;
                cur_id_next        = {it_rx, 8'h00};
                phase_next         = PH_ID;
                timer_running_next = 1'b1;
                tick_count_next    = '0;
              end
              PH_ID: begin
                res_reply_next = RP_ID;
                cur_id_next    = cur_id | {8'h00, it_rx};
                phase_next     = PH_LEN;
                res_event_next = EV_ID;
              end
              PH_LEN: begin
                cur_len_next  = it_rx;
                byte_pos_next = '0;
                if (hdr_ok && it_dir == DIR_RX) begin
                  res_reply_next = RP_RX_OK;
                  rx_sum_next    = hdr_sum;
                  phase_next     = (it_rx == '0) ? PH_RX_CHK : PH_RX_DATA;
                end else if (hdr_ok && it_dir == DIR_TX) begin
                  // checksum walk over the staged bytes, reply set afterwards
                  acc_next       = hdr_sum;
                  walk_cnt_next  = '0;
                  walk_pend_next = 1'b0;
                  seq_next       = SQ_WALK;
                  phase_next     = (it_rx == '0) ? PH_TX_CHK : PH_TX_DATA;
                end else begin
                  res_reply_next = hdr_ok ? RP_NO_DIR : RP_REJECT;
                  phase_next     = (it_rx == '0) ? PH_IDLE : PH_IGNORE;
                  if (it_rx == '0) begin
                    timer_running_next = 1'b0;
                  end
                end
              end
              PH_RX_DATA: begin
                res_reply_next = RP_RX_DATA;
                rx_sum_next    = rx_sum + it_rx;
                res_event_next = EV_DATA;
                res_didx_next  = byte_pos[5:0];
                res_dbyte_next = it_rx;
                byte_pos_next  = pos_inc;
                if (pos_inc >= cur_len) begin
                  phase_next = PH_RX_CHK;
                end
              end
              PH_RX_CHK: begin
                res_reply_next     = RP_RX_CHK;
                res_event_next     = (it_rx == ~rx_sum) ? EV_GOOD : EV_BAD;
                phase_next         = PH_IDLE;
                timer_running_next = 1'b0;
              end
              PH_TX_DATA: begin
                byte_pos_next = pos_inc;
                if (pos_inc >= cur_len) begin
                  res_reply_next = tx_check;
                  phase_next     = PH_TX_CHK;
                end else begin
                  seq_next = SQ_FETCH;
                end
              end
              PH_TX_CHK: begin
                res_reply_next = RP_TX_CHK;
                phase_next     = PH_TX_DONE;
              end
              PH_TX_DONE: begin
                res_reply_next     = RP_TX_DONE;
                phase_next         = PH_IDLE;
                timer_running_next = 1'b0;
              end
              PH_IGNORE: begin
                res_reply_next = RP_IGNORE;
                byte_pos_next  = pos_inc;
                if (pos_inc >= cur_len) begin
                  phase_next         = PH_IDLE;
                  timer_running_next = 1'b0;
                end
              end
              default: begin
                res_reply_next = RP_UNUSED;
              end
            endcase
          end
          OP_EMPTY: begin
            res_valid_next = 1'b1;
            res_reply_next = RP_EMPTY;
          end
          OP_TICK: begin
            if (timer_running) begin
              tick_count_next = tick_inc;
              if (tick_inc > timeout_ticks) begin
                timer_running_next = 1'b0;
                phase_next         = PH_IDLE;
                if (phase != PH_IDLE) begin
                  res_event_next = EV_TIMEOUT;
                end
              end
            end
          end
          OP_LOAD: begin
            // store write happens this cycle
          end
        endcase
      end

      SQ_WALK: begin
        // read issued at walk_cnt, data added in the next cycle
        if (walk_pend) begin
          acc_next = acc + ram_rd_data;
        end
        if (walk_cnt < cur_len) begin
          walk_cnt_next  = walk_cnt + 8'd1;
          walk_pend_next = 1'b1;
        end else begin
          walk_pend_next = 1'b0;
          if (!walk_pend) begin
            tx_check_next = ~acc;
            if (cur_len == '0) begin
              res_reply_next = ~acc;
              seq_next       = SQ_OUT;
            end else begin
              seq_next = SQ_FETCH;
            end
          end
        end
      end

      SQ_FETCH: begin
        seq_next = SQ_LOAD;
      end

      SQ_LOAD: begin
        res_reply_next = ram_rd_data;
        seq_next       = SQ_OUT;
      end

      SQ_OUT: begin
        if (!result_stall) begin
          seq_next = SQ_READY;
        end
      end

      default: begin
        seq_next = SQ_READY;
      end
    endcase
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame-over-SPI slave framer. Frames, header
// answers, staging loads and timer ticks are sent through the item channel,
// and every result is checked field by field against a software copy of
// the framer held in this module. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lfs_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int TAIL_CYCLES  = 200;
  localparam int MAX_PRINTS   = 100;

  typedef struct packed {
    op_t        op;
    logic [7:0] rx;
    logic       accept;
    logic [7:0] len;
    logic [1:0] dir;
    logic [5:0] idx;
    logic [7:0] val;
  } spi_item_t;

  typedef struct packed {
    logic        reply_valid;
    logic [7:0]  reply_byte;
    ev_t         ev;
    logic [15:0] id;
    logic [7:0]  len;
    logic [5:0]  didx;
    logic [7:0]  dbyte;
  } framer_out_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [TIMEOUT_W-1:0] cfg_wdata;
  logic                 item_valid;
  logic                 item_stall;
  logic [1:0]           operation;
  logic [7:0]           rx_byte;
  logic                 hdr_accept;
  logic [7:0]           hdr_len;
  logic [1:0]           hdr_dir;
  logic [5:0]           load_index;
  logic [7:0]           load_byte;
  logic                 result_valid;
  logic                 result_stall;
  logic                 reply_valid;
  logic [7:0]           reply_byte;
  logic [2:0]           event_res;
  logic [15:0]          frame_id;
  logic [7:0]           frame_len;
  logic [5:0]           data_index;
  logic [7:0]           data_byte;

  // software copy of the framer
  phase_t     fr_phase;
  logic [15:0] fr_id;
  logic [7:0] fr_len;
  logic [7:0] fr_pos;
  logic [7:0] fr_rx_sum;
  logic [7:0] fr_tx_check;
  logic       fr_timer_on;
  logic [19:0] fr_ticks;
  logic [19:0] fr_timeout;
  logic [7:0] staging [STORE_DEPTH];

  framer_out_t awaited_out[$];

  int cycle_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int errors = 0;
  int n_good = 0;
  int n_bad = 0;
  int n_timeout = 0;
  int n_echo = 0;
  int gap_max = 16;
  int stall_max = 16;
  int hold_req = 0;

  lin_frame_over_spi_slave_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .rx_byte      (rx_byte),
    .hdr_accept   (hdr_accept),
    .hdr_len      (hdr_len),
    .hdr_dir      (hdr_dir),
    .load_index   (load_index),
    .load_byte    (load_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .reply_valid  (reply_valid),
    .reply_byte   (reply_byte),
    .event_res    (event_res),
    .frame_id     (frame_id),
    .frame_len    (frame_len),
    .data_index   (data_index),
    .data_byte    (data_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("watchdog: run stopped after %0d cycles", cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------- framer copy

  function automatic void framer_reset();
    fr_phase    = PH_IDLE;
    fr_id       = '0;
    fr_len      = '0;
    fr_pos      = '0;
    fr_rx_sum   = '0;
    fr_tx_check = '0;
    fr_timer_on = 1'b0;
    fr_ticks    = '0;
    fr_timeout  = TIMEOUT_RESET;
  endfunction

  function automatic logic [7:0] frame_hdr_sum();
    return fr_id[15:8] + fr_id[7:0] + fr_len;
  endfunction

  function automatic framer_out_t framer_step(spi_item_t it);
    framer_out_t o;
    logic [7:0] sum;
    o.reply_valid = 1'b0;
    o.reply_byte  = '0;
    o.ev          = EV_NONE;
    o.didx        = '0;
    o.dbyte       = '0;
    case (it.op)
      OP_BYTE: begin
        o.reply_valid = 1'b1;
        case (fr_phase)
          PH_IDLE: begin
            o.reply_byte = RP_START;
            fr_id = {it.rx, 8'h00};
            fr_phase = PH_ID;
            fr_timer_on = 1'b1;
            fr_ticks = '0;
          end
          PH_ID: begin
            o.reply_byte = RP_ID;
            fr_id = fr_id | {8'h00, it.rx};
            fr_phase = PH_LEN;
            o.ev = EV_ID;
          end
          PH_LEN: begin
            fr_len = it.rx;
            fr_pos = '0;
            if (it.accept && it.len == it.rx && it.rx <= MAX_DATA_DEF) begin
              if (it.dir == DIR_RX) begin
                o.reply_byte = RP_RX_OK;
                fr_rx_sum = frame_hdr_sum();
                if (it.rx == 8'd0) fr_phase = PH_RX_CHK;
                else fr_phase = PH_RX_DATA;
              end else if (it.dir == DIR_TX) begin
                // checksum is fixed here from the store as it stands now
                sum = frame_hdr_sum();
                for (int i = 0; i < int'(it.rx); i++) sum = sum + staging[i];
                fr_tx_check = ~sum;
                if (it.rx == 8'd0) begin
                  o.reply_byte = fr_tx_check;
                  fr_phase = PH_TX_CHK;
                end else begin
                  o.reply_byte = staging[0];
                  fr_phase = PH_TX_DATA;
                end
              end else begin
                o.reply_byte = RP_NO_DIR;
                if (it.rx == 8'd0) fr_phase = PH_IDLE;
                else fr_phase = PH_IGNORE;
              end
            end else begin
              o.reply_byte = RP_REJECT;
              if (it.rx == 8'd0) fr_phase = PH_IDLE;
              else fr_phase = PH_IGNORE;
            end
            if (fr_phase == PH_IDLE) fr_timer_on = 1'b0;
          end
          PH_RX_DATA: begin
            o.reply_byte = RP_RX_DATA;
            fr_rx_sum = fr_rx_sum + it.rx;
            o.ev = EV_DATA;
            o.didx = fr_pos[5:0];
            o.dbyte = it.rx;
            fr_pos = fr_pos + 8'd1;
            if (fr_pos >= fr_len) fr_phase = PH_RX_CHK;
          end
          PH_RX_CHK: begin
            o.reply_byte = RP_RX_CHK;
            if (it.rx == ~fr_rx_sum) o.ev = EV_GOOD;
            else o.ev = EV_BAD;
            fr_phase = PH_IDLE;
            fr_timer_on = 1'b0;
          end
          PH_TX_DATA: begin
            fr_pos = fr_pos + 8'd1;
            if (fr_pos >= fr_len) begin
              o.reply_byte = fr_tx_check;
              fr_phase = PH_TX_CHK;
            end else begin
              o.reply_byte = staging[fr_pos[5:0]];
            end
          end
          PH_TX_CHK: begin
            o.reply_byte = RP_TX_CHK;
            fr_phase = PH_TX_DONE;
          end
          PH_TX_DONE: begin
            o.reply_byte = RP_TX_DONE;
            fr_phase = PH_IDLE;
            fr_timer_on = 1'b0;
          end
          PH_IGNORE: begin
            o.reply_byte = RP_IGNORE;
            fr_pos = fr_pos + 8'd1;
            if (fr_pos >= fr_len) begin
              fr_phase = PH_IDLE;
              fr_timer_on = 1'b0;
            end
          end
          default: o.reply_byte = RP_UNUSED;
        endcase
      end
      OP_EMPTY: begin
        o.reply_valid = 1'b1;
        o.reply_byte = RP_EMPTY;
      end
      OP_TICK: begin
        if (fr_timer_on) begin
          if (fr_ticks != 20'hFFFFF) fr_ticks = fr_ticks + 20'd1;
          if (fr_ticks > fr_timeout) begin
            fr_timer_on = 1'b0;
            if (fr_phase != PH_IDLE) o.ev = EV_TIMEOUT;
            fr_phase = PH_IDLE;
          end
        end
      end
      default: staging[it.idx] = it.val;
    endcase
    o.id = fr_id;
    o.len = fr_len;
    return o;
  endfunction

  // ---------------------------------------------------------------- sending

  function automatic spi_item_t any_item(op_t op);
    spi_item_t it;
    it.op     = op;
    it.rx     = 8'($urandom);
    it.accept = 1'($urandom);
    it.len    = 8'($urandom);
    it.dir    = 2'($urandom);
    it.idx    = 6'($urandom);
    it.val    = 8'($urandom);
    return it;
  endfunction

  // valid stays high into the next item when no gap is drawn
  task automatic send_item(spi_item_t it);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    operation  <= it.op;
    rx_byte    <= it.rx;
    hdr_accept <= it.accept;
    hdr_len    <= it.len;
    hdr_dir    <= it.dir;
    load_index <= it.idx;
    load_byte  <= it.val;
    forever begin
      @(posedge clk);
      if (!item_stall) break;
    end
    awaited_out.push_back(framer_step(it));
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    spi_item_t it;
    it = any_item(OP_BYTE);
    it.rx = b;
    send_item(it);
  endtask

  task automatic send_len(logic [7:0] len, logic acc, logic [7:0] want_len,
                          logic [1:0] dir);
    spi_item_t it;
    it = any_item(OP_BYTE);
    it.rx = len;
    it.accept = acc;
    it.len = want_len;
    it.dir = dir;
    send_item(it);
  endtask

  task automatic send_load(logic [5:0] idx, logic [7:0] val);
    spi_item_t it;
    it = any_item(OP_LOAD);
    it.idx = idx;
    it.val = val;
    send_item(it);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (awaited_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(logic [19:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    fr_timeout = v;
  endtask

  // runs the current frame to idle; may_drop leaves it hanging now and then
  task automatic finish_frame(bit may_drop);
    spi_item_t it;
    int r;
    while (fr_phase != PH_IDLE) begin
      r = $urandom_range(0, 99);
      if (may_drop && r == 0) return;
      if (r < 4) begin
        send_item(any_item(OP_TICK));
      end else if (r < 7) begin
        send_item(any_item(OP_EMPTY));
      end else if (r < 9) begin
        send_item(any_item(OP_LOAD));
      end else begin
        it = any_item(OP_BYTE);
        if (fr_phase == PH_RX_CHK && $urandom_range(0, 9) != 0) it.rx = ~fr_rx_sum;
        send_item(it);
      end
    end
  endtask

  task automatic run_frame();
    logic [15:0] id;
    logic [7:0]  len;
    logic [7:0]  want_len;
    logic [1:0]  dir;
    logic        acc;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) id = 16'hFFFF;
    else if (r < 16) id = 16'h0000;
    else id = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70) len = 8'($urandom_range(0, 6));
    else if (r < 90) len = 8'($urandom_range(7, 63));
    else if (r < 96) len = 8'd64;
    else len = 8'($urandom_range(65, 90));
    r = $urandom_range(0, 99);
    if (r < 50) dir = DIR_RX;
    else if (r < 90) dir = DIR_TX;
    else dir = 2'($urandom_range(2, 3));
    acc = 1'b1;
    want_len = len;
    r = $urandom_range(0, 99);
    if (r < 8) acc = 1'b0;
    else if (r < 14) want_len = len ^ 8'($urandom_range(1, 255));
    send_byte(id[15:8]);
    send_byte(id[7:0]);
    send_len(len, acc, want_len, dir);
    finish_frame(1'b1);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("mismatch at result %0d: %s got %0h expected %0h",
               results_seen, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result();
    framer_out_t want;
    if (awaited_out.size() == 0) begin
      report_mismatch("result with nothing outstanding", 32'(reply_byte), 32'd0);
      return;
    end
    want = awaited_out.pop_front();
    results_seen++;
    check_field("reply_valid", 32'(reply_valid), 32'(want.reply_valid));
    check_field("reply_byte", 32'(reply_byte), 32'(want.reply_byte));
    check_field("event_res", 32'(event_res), 32'(want.ev));
    check_field("frame_id", 32'(frame_id), 32'(want.id));
    check_field("frame_len", 32'(frame_len), 32'(want.len));
    check_field("data_index", 32'(data_index), 32'(want.didx));
    check_field("data_byte", 32'(data_byte), 32'(want.dbyte));
    case (want.ev)
      EV_GOOD:    n_good++;
      EV_BAD:     n_bad++;
      EV_TIMEOUT: n_timeout++;
      EV_DATA:    n_echo++;
      default: ;
    endcase
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) check_result();
    end
  end

  // result side: a random hold before each transfer, or a long hold on request
  initial begin
    int n;
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = $urandom_range(0, stall_max);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !rst));
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_store_preload();
    send_load(6'd0, 8'h00);
    send_load(6'd63, 8'hFF);
    for (int i = 1; i < 63; i++) send_load(6'(i), 8'($urandom));
  endtask

  task automatic test_rx_frames();
    // zero length goes straight to the checksum
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_len(8'd0, 1'b1, 8'd0, DIR_RX);
    send_byte(~fr_rx_sum);
    // data extremes and a wrong checksum
    send_byte(8'h00);
    send_byte(8'h00);
    send_len(8'd2, 1'b1, 8'd2, DIR_RX);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(fr_rx_sum);
    // transmit-empty in the middle of a frame
    send_byte(8'h3C);
    send_byte(8'hA5);
    send_len(8'd1, 1'b1, 8'd1, DIR_RX);
    send_item(any_item(OP_EMPTY));
    send_byte(8'h5A);
    send_byte(~fr_rx_sum);
  endtask

  task automatic test_tx_frames();
    // zero length loads the checksum at once
    send_byte(8'h12);
    send_byte(8'h34);
    send_len(8'd0, 1'b1, 8'd0, DIR_TX);
    send_byte(8'h00);
    send_byte(8'h00);
    // store rewritten mid-frame: data follows the store, checksum does not
    send_byte(8'h80);
    send_byte(8'h01);
    send_len(8'd2, 1'b1, 8'd2, DIR_TX);
    send_load(6'd1, ~staging[1]);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    // longest frame
    send_byte(8'hC3);
    send_byte(8'h3C);
    send_len(8'd64, 1'b1, 8'd64, DIR_TX);
    finish_frame(1'b0);
  endtask

  task automatic test_header_rejects();
    // not accepted
    send_byte(8'h01);
    send_byte(8'h02);
    send_len(8'd1, 1'b0, 8'd1, DIR_RX);
    send_byte(8'h55);
    // length differs from the expected one
    send_byte(8'h03);
    send_byte(8'h04);
    send_len(8'd3, 1'b1, 8'd4, DIR_RX);
    finish_frame(1'b0);
    // length over the maximum although expected
    send_byte(8'h05);
    send_byte(8'h06);
    send_len(8'd65, 1'b1, 8'd65, DIR_RX);
    finish_frame(1'b0);
    // no direction, with and without data
    send_byte(8'h07);
    send_byte(8'h08);
    send_len(8'd0, 1'b1, 8'd0, 2'd2);
    send_byte(8'h09);
    send_byte(8'h0A);
    send_len(8'd2, 1'b1, 8'd2, 2'd3);
    finish_frame(1'b0);
    // rejected with zero length returns to idle
    send_byte(8'h0B);
    send_byte(8'h0C);
    send_len(8'd0, 1'b0, 8'd7, DIR_TX);
  endtask

  task automatic test_timeouts();
    wait_drained();
    write_timeout(20'd0);
    send_item(any_item(OP_TICK));
    send_byte(8'h21);
    send_item(any_item(OP_TICK));
    send_item(any_item(OP_TICK));
    wait_drained();
    write_timeout(20'd2);
    send_byte(8'h22);
    send_byte(8'h33);
    send_len(8'd255, 1'b1, 8'd255, DIR_RX);
    send_byte(8'h44);
    repeat (3) send_item(any_item(OP_TICK));
    wait_drained();
    write_timeout(20'hFFFFF);
    send_byte(8'h66);
    repeat (30) send_item(any_item(OP_TICK));
    finish_frame(1'b0);
    wait_drained();
    write_timeout(TIMEOUT_RESET);
  endtask

  task automatic test_back_pressure();
    wait_drained();
    gap_max = 0;
    hold_req = 400;
    repeat (3) run_frame();
    finish_frame(1'b0);
    // sender holds back until everything is back
    wait_drained();
    gap_max = 16;
  endtask

  task automatic test_random_traffic();
    int stop_at;
    logic [19:0] tmo;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: tmo = 20'd0;
        1: tmo = 20'd3;
        2: tmo = TIMEOUT_RESET;
        3: tmo = 20'hFFFFF;
        4: tmo = 20'($urandom_range(1, 12));
        default: tmo = 20'($urandom);
      endcase
      wait_drained();
      write_timeout(tmo);
      gap_max = (p == 2) ? 0 : 16;
      stall_max = (p == 2 || p == 4) ? 0 : 16;
      stop_at = items_sent + 80;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(any_item(op_t'($urandom_range(0, 3))));
        end else begin
          if (fr_phase != PH_IDLE && $urandom_range(0, 1) == 1) finish_frame(1'b0);
          run_frame();
        end
      end
    end
    finish_frame(1'b0);
    gap_max = 16;
    stall_max = 16;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    item_valid <= 1'b0;
    operation  <= OP_BYTE;
    rx_byte    <= '0;
    hdr_accept <= 1'b0;
    hdr_len    <= '0;
    hdr_dir    <= '0;
    load_index <= '0;
    load_byte  <= '0;
    framer_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_store_preload();
    test_rx_frames();
    test_tx_frames();
    test_header_rejects();
    test_timeouts();
    test_back_pressure();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_out.size() != 0)
      report_mismatch("results never delivered", 32'(awaited_out.size()), 32'd0);

    $display("run: %0d items, %0d results checked, %0d mismatches, %0d cycles",
             items_sent, results_seen, errors, cycle_count);
    $display("frames: %0d good, %0d bad checksum, %0d timed out, %0d data echoes",
             n_good, n_bad, n_timeout, n_echo);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lfs_pkg.sv
sv/lfs_stage_ram.sv
sv/lin_frame_over_spi_slave_unit.sv
tb/sv/tb_top.sv
